@@ hw/rtl/cel_pkg.sv @@
// Shared constants, command and status types for the cross-entropy loss block.
package cel_pkg;

  // Class index range
  localparam int MAX_CLASSES = 1024;
  localparam int IDX_W       = 10;
  localparam int IDX_MAX_INT = (MAX_CLASSES - 1 < 1023) ? (MAX_CLASSES - 1) : 1023;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_MAX_INT);

  // Field widths
  localparam int PROB_W  = 16;
  localparam int LOSS_W  = 24;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 40;
  localparam int NL_W    = 20;   // -ln(p) in Q4.16, at most about 10.4
  localparam int TERM_W  = 21;   // target * -ln(p) in Q5.16

  // Squaring rounds of the log2 fraction
  localparam int ROUNDS   = 16;
  localparam int ROUND_W  = 4;
  localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Saturation limits
  localparam logic [LOSS_W-1:0] LOSS_MAX = {LOSS_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Result payload width and padded stream width
  localparam int OUT_W   = LOSS_W + 2 * IDX_W + 1 + 2 * CNT_W + SUM_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;
  localparam int IN_TW   = 2 * PROB_W;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take a new element
    logic round;   // one squaring round of the log
    logic ln;      // scale log2 to ln
    logic term;    // weight by target
    logic acc;     // add into the sample loss
    logic emit;    // close the sample and load the result register
  } cel_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;      // held element closes its sample
    logic out_free;  // result register can take a new result
  } cel_status_t;

endpackage

@@ hw/rtl/cel_ctrl.sv @@
// Controller state machine: sequences one element through the datapath.
module cel_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cel_pkg::cel_status_t  status,
  output cel_pkg::cel_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_LN    = 3'd2;
  localparam logic [2:0] ST_TERM  = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [cel_pkg::ROUND_W-1:0] round_cnt;

  assign in_ready = (state == ST_IDLE);

  // Decode commands from the state
  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && in_valid;
    cmd.round = (state == ST_ROUND);
    cmd.ln    = (state == ST_LN);
    cmd.term  = (state == ST_TERM);
    cmd.acc   = (state == ST_ACC);
    cmd.emit  = (state == ST_EMIT) && status.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_ROUND;
      ST_ROUND: if (round_cnt == cel_pkg::ROUND_LAST) state_next = ST_LN;
      ST_LN:    state_next = ST_TERM;
      ST_TERM:  state_next = ST_ACC;
      ST_ACC:   state_next = status.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.round) begin
        round_cnt <= round_cnt + 1'b1;
      end else begin
        round_cnt <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/cel_dp.sv @@
// Datapath: log unit, loss accumulation, argmax tracking, counters and result register.
module cel_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  cel_pkg::cel_cmd_t           cmd,
  output cel_pkg::cel_status_t        status,
  input  logic [cel_pkg::PROB_W-1:0]  prob,
  input  logic [cel_pkg::PROB_W-1:0]  target,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cel_pkg::OUT_W-1:0]   out_data
);

  // Count leading zeros of a nonzero 16-bit value
  function automatic logic [3:0] lead_zeros(input logic [15:0] x);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 4'(15 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Element held during processing
  logic [cel_pkg::PROB_W-1:0] tgt_q;
  logic                       last_q;

  // Log unit registers
  logic [15:0]               mant;
  logic [3:0]                shift;
  logic [15:0]               frac;
  logic [cel_pkg::NL_W-1:0]  nl;
  logic [cel_pkg::TERM_W-1:0] term;

  // Per-sample and running state
  logic [cel_pkg::PROB_W-1:0] best_prob;
  logic [cel_pkg::IDX_W-1:0]  best_index;
  logic [cel_pkg::IDX_W-1:0]  element_count;
  logic [cel_pkg::IDX_W-1:0]  hot_index;
  logic [cel_pkg::LOSS_W-1:0] partial_loss;
  logic [cel_pkg::CNT_W-1:0]  hits;
  logic [cel_pkg::CNT_W-1:0]  misses;
  logic [cel_pkg::SUM_W-1:0]  loss_sum;

  // Combinational helpers
  logic [15:0]                clamped;
  logic [3:0]                 lz;
  logic [31:0]                sq;
  logic [16:0]                sq_top;
  logic [19:0]                v;
  logic [52:0]                ln_prod;
  logic [35:0]                term_prod;
  logic [cel_pkg::LOSS_W:0]   loss_add;
  logic                       hit;
  logic [cel_pkg::CNT_W-1:0]  hits_next;
  logic [cel_pkg::CNT_W-1:0]  misses_next;
  logic [cel_pkg::SUM_W:0]    sum_add;
  logic [cel_pkg::SUM_W-1:0]  loss_sum_next;

  assign status.last     = last_q;
  assign status.out_free = !out_valid || out_ready;

  // Clamp probability to [one LSB, one] and normalize
  always_comb begin
    if (prob == '0) begin
      clamped = 16'd1;
    end else if (prob > 16'd32768) begin
      clamped = 16'd32768;
    end else begin
      clamped = prob;
    end
    lz = lead_zeros(clamped);
  end

  // One squaring round, log scaling, target weighting and the loss addition
  assign sq        = 32'(mant) * 32'(mant);
  assign sq_top    = sq[31:15];
  assign v         = {shift, 16'd0} - {4'd0, frac};
  assign ln_prod   = 53'(v) * 53'(cel_pkg::LN2_Q32) + 53'h0_0000_8000_0000;
  assign term_prod = 36'(tgt_q) * 36'(nl) + 36'd16384;
  assign loss_add  = {1'b0, partial_loss} + (cel_pkg::LOSS_W+1)'(term);

  // Sample close: hit, counters and total
  always_comb begin
    hit         = (best_index == hot_index);
    hits_next   = hits;
    misses_next = misses;
    if (hit) begin
      if (hits != cel_pkg::CNT_MAX) hits_next = hits + 1'b1;
    end else begin
      if (misses != cel_pkg::CNT_MAX) misses_next = misses + 1'b1;
    end
    sum_add       = {1'b0, loss_sum} + (cel_pkg::SUM_W+1)'(partial_loss);
    loss_sum_next = sum_add[cel_pkg::SUM_W] ? cel_pkg::SUM_MAX : sum_add[cel_pkg::SUM_W-1:0];
  end

  // Payload registers of the log unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_q <= target;
      mant  <= clamped << lz;
      shift <= lz;
      frac  <= '0;
    end
    if (cmd.round) begin
      mant <= sq_top[16] ? sq_top[16:1] : sq_top[15:0];
      frac <= {frac[14:0], sq_top[16]};
    end
    if (cmd.ln) begin
      nl <= ln_prod[32 +: cel_pkg::NL_W];
    end
    if (cmd.term) begin
      term <= term_prod[15 +: cel_pkg::TERM_W];
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {loss_sum_next, misses_next, hits_next, hit, hot_index, best_index,
                   partial_loss};
    end
  end

  // Sample and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_q        <= 1'b0;
      best_prob     <= '0;
      best_index    <= '0;
      element_count <= '0;
      hot_index     <= '0;
      partial_loss  <= '0;
      hits          <= '0;
      misses        <= '0;
      loss_sum      <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Track argmax and the hot index on arrival
      if (cmd.load) begin
        last_q <= last;
        if (prob > best_prob) begin
          best_prob  <= prob;
          best_index <= element_count;
        end
        if (target != '0) hot_index <= element_count;
      end
      // Accumulate with saturation, advance the element index
      if (cmd.acc) begin
        partial_loss <= loss_add[cel_pkg::LOSS_W] ? cel_pkg::LOSS_MAX
                                                  : loss_add[cel_pkg::LOSS_W-1:0];
        if (!last_q && element_count < cel_pkg::IDX_MAX) begin
          element_count <= element_count + 1'b1;
        end
      end
      // Close the sample
      if (cmd.emit) begin
        hits          <= hits_next;
        misses        <= misses_next;
        loss_sum      <= loss_sum_next;
        best_prob     <= '0;
        best_index    <= '0;
        element_count <= '0;
        partial_loss  <= '0;
      end
      // Result handshake
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/cross_entropy_loss_accuracy.sv @@
// Top level of the streaming cross-entropy loss and argmax accuracy block.
// One class element per input transfer (prob in Q1.15, target in Q1.15, tlast on the
// final class of a sample). Between its transfer and the next free slot each element
// is taken, runs the 16 squaring rounds of the log2 fraction (one 16x16 multiply per
// cycle), is scaled to ln, weighted by the target and accumulated. The element marked
// last then loads the result register, and waits there while an earlier result has
// not yet been transferred. One result transfer per sample carries the sample loss,
// both indices, the hit flag and the saturating running totals; the input side is
// taken again while that result waits.
module cross_entropy_loss_accuracy (
  input  logic                         clk,
  input  logic                         rst,
  // prob [15:0], target [31:16]
  input  logic [cel_pkg::IN_TW-1:0]    s_tdata,
  input  logic                         s_tlast,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // sample_loss [23:0], predicted_index [33:24], target_index [43:34], hit [44],
  // correct_total [76:45], incorrect_total [108:77], loss_total [148:109], zeros above
  output logic [cel_pkg::OUT_TW-1:0]   m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready
);

  cel_pkg::cel_cmd_t              cmd;
  cel_pkg::cel_status_t           status;
  logic [cel_pkg::OUT_W-1:0]      out_data;

  // Sequencer
  cel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state
  cel_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .prob      (s_tdata[cel_pkg::PROB_W-1:0]),
    .target    (s_tdata[2*cel_pkg::PROB_W-1:cel_pkg::PROB_W]),
    .last      (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  // Pad the result to whole bytes
  assign m_tdata = cel_pkg::OUT_TW'(out_data);

endmodule

@@ hw/rtl/cel_checker.sv @@
// Port-level checks for the cross-entropy loss block, bound to the top level.
module cel_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [cel_pkg::OUT_TW-1:0]  m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One element at a time: input closes after each transfer
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an element is in work");

  // Hit flag agrees with the two indices
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44] == (m_tdata[33:24] == m_tdata[43:34])))
    else $error("hit flag disagrees with indices");

  // Running total never falls below the sample loss it includes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[148:109] >= 40'(m_tdata[23:0])))
    else $error("loss total below sample loss");

  // A new result appears as the sample closes and the input side reopens
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result appeared outside a sample close");

endmodule

bind cross_entropy_loss_accuracy cel_checker u_cel_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ tb/sv/tb.sv @@
// Testbench for the streaming cross-entropy loss and argmax accuracy block.
`timescale 1ns / 1ps

module tb;

  localparam int ITEM_GOAL    = 1900;
  localparam int LONG_LEN     = 1030;
  localparam int RAND_GOAL    = ITEM_GOAL - LONG_LEN;
  localparam int TAIL_CYCLES  = 50;

  // One sample result as carried on the master stream
  typedef struct packed {
    logic [cel_pkg::SUM_W-1:0]  loss_total;
    logic [cel_pkg::CNT_W-1:0]  incorrect_total;
    logic [cel_pkg::CNT_W-1:0]  correct_total;
    logic                       hit;
    logic [cel_pkg::IDX_W-1:0]  target_index;
    logic [cel_pkg::IDX_W-1:0]  predicted_index;
    logic [cel_pkg::LOSS_W-1:0] sample_loss;
  } sample_result_t;

  // One element with an optional hand-written result for its sample
  typedef struct {
    logic [cel_pkg::PROB_W-1:0] prob;
    logic [cel_pkg::PROB_W-1:0] target;
    logic                       last;
    logic                       known;
    logic [cel_pkg::LOSS_W-1:0] loss;
    logic [cel_pkg::IDX_W-1:0]  pidx;
    logic [cel_pkg::IDX_W-1:0]  tidx;
    logic                       hit;
  } element_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic [cel_pkg::IN_TW-1:0]    s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [cel_pkg::OUT_TW-1:0]   m_tdata;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;

  // Predictor state
  logic [cel_pkg::PROB_W-1:0]   arg_best_prob;
  logic [cel_pkg::IDX_W-1:0]    arg_best_idx;
  logic [cel_pkg::IDX_W-1:0]    elem_idx;
  logic [cel_pkg::IDX_W-1:0]    hot_idx;
  logic [cel_pkg::LOSS_W-1:0]   sample_loss_acc;
  logic [cel_pkg::CNT_W-1:0]    hit_cnt;
  logic [cel_pkg::CNT_W-1:0]    miss_cnt;
  logic [cel_pkg::SUM_W-1:0]    loss_acc_total;

  sample_result_t      sample_expect_q[$];
  element_t            directed_rows[$];
  sample_result_t      got_res;
  sample_result_t      exp_res;
  int                  err_cnt = 0;
  int                  items_sent = 0;
  int                  tx_idle_pct = 0;
  int                  rx_stall_pct = 0;

  cross_entropy_loss_accuracy u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always #4 clk = ~clk;

  // -ln(x / 32768) in Q4.16 via a squaring log2 fraction
  function automatic logic [19:0] neg_ln_q16(input logic [cel_pkg::PROB_W-1:0] x);
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] prod;
    logic [15:0] frac;
    int          shifts;
    m = (x == 0) ? 64'd1 : ((x > 16'd32768) ? 64'd32768 : 64'(x));
    shifts = 0;
    frac = '0;
    while (m < 64'd32768) begin
      m = m << 1;
      shifts++;
    end
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'd65536) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    v = 64'(shifts) * 64'd65536 - 64'(frac);
    prod = v * 64'(cel_pkg::LN2_Q32) + 64'h8000_0000;
    return 20'(prod >> 32);
  endfunction

  // Fold one element into the sample; close it on last
  task automatic accumulate_element(input logic [cel_pkg::PROB_W-1:0] p,
                                    input logic [cel_pkg::PROB_W-1:0] t,
                                    input logic last, output logic done,
                                    output sample_result_t r);
    logic [63:0] term;
    logic [63:0] acc;
    r = '0;
    if (p > arg_best_prob) begin
      arg_best_prob = p;
      arg_best_idx = elem_idx;
    end
    term = (64'(t) * 64'(neg_ln_q16(p)) + 64'h4000) >> 15;
    acc = 64'(sample_loss_acc) + term;
    sample_loss_acc = (acc > 64'(cel_pkg::LOSS_MAX)) ? cel_pkg::LOSS_MAX
                                                     : acc[cel_pkg::LOSS_W-1:0];
    if (t != 0) hot_idx = elem_idx;
    done = last;
    if (!last) begin
      if (elem_idx < cel_pkg::IDX_MAX) elem_idx++;
    end else begin
      r.hit = (arg_best_idx == hot_idx);
      if (r.hit) begin
        if (hit_cnt != cel_pkg::CNT_MAX) hit_cnt++;
      end else begin
        if (miss_cnt != cel_pkg::CNT_MAX) miss_cnt++;
      end
      acc = 64'(loss_acc_total) + 64'(sample_loss_acc);
      loss_acc_total = (acc > 64'(cel_pkg::SUM_MAX)) ? cel_pkg::SUM_MAX
                                                     : acc[cel_pkg::SUM_W-1:0];
      r.sample_loss = sample_loss_acc;
      r.predicted_index = arg_best_idx;
      r.target_index = hot_idx;
      r.correct_total = hit_cnt;
      r.incorrect_total = miss_cnt;
      r.loss_total = loss_acc_total;
      arg_best_prob = '0;
      arg_best_idx = '0;
      elem_idx = '0;
      sample_loss_acc = '0;
    end
  endtask

  // Drive one element, wait for its transfer, then predict
  task automatic send_element(input element_t e);
    int             gap;
    logic           done;
    sample_result_t r;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {e.target, e.prob};
    s_tlast  <= e.last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    accumulate_element(e.prob, e.target, e.last, done, r);
    if (done) begin
      if (e.known) begin
        r.sample_loss = e.loss;
        r.predicted_index = e.pidx;
        r.target_index = e.tidx;
        r.hit = e.hit;
      end
      sample_expect_q.push_back(r);
    end
  endtask

  task automatic add_row(input logic [cel_pkg::PROB_W-1:0] p,
                         input logic [cel_pkg::PROB_W-1:0] t,
                         input logic last, input logic known,
                         input logic [cel_pkg::LOSS_W-1:0] loss,
                         input logic [cel_pkg::IDX_W-1:0] pidx,
                         input logic [cel_pkg::IDX_W-1:0] tidx,
                         input logic hit);
    element_t e;
    e = '{p, t, last, known, loss, pidx, tidx, hit};
    directed_rows.push_back(e);
  endtask

  function automatic element_t rand_element(input logic [cel_pkg::PROB_W-1:0] p,
                                            input logic [cel_pkg::PROB_W-1:0] t,
                                            input logic last);
    element_t e;
    e = '{p, t, last, 1'b0, '0, '0, '0, 1'b0};
    return e;
  endfunction

  function automatic logic [cel_pkg::PROB_W-1:0] rand_prob();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'd32768;
      2:       return cel_pkg::PROB_W'($urandom_range(65535));
      default: return cel_pkg::PROB_W'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [cel_pkg::PROB_W-1:0] rand_target();
    case ($urandom_range(5))
      0:       return cel_pkg::PROB_W'($urandom_range(65535));
      1:       return cel_pkg::PROB_W'($urandom_range(32768));
      default: return '0;
    endcase
  endfunction

  task automatic drain_results();
    while (sample_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare each result transfer with the oldest pending sample
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sample_expect_q.size() == 0) begin
        $error("result transfer with no sample pending");
        err_cnt++;
      end else begin
        exp_res = sample_expect_q.pop_front();
        got_res = m_tdata[cel_pkg::OUT_W-1:0];
        check_field("sample_loss", 64'(exp_res.sample_loss), 64'(got_res.sample_loss));
        check_field("predicted_index", 64'(exp_res.predicted_index),
                    64'(got_res.predicted_index));
        check_field("target_index", 64'(exp_res.target_index), 64'(got_res.target_index));
        check_field("hit", 64'(exp_res.hit), 64'(got_res.hit));
        check_field("correct_total", 64'(exp_res.correct_total),
                    64'(got_res.correct_total));
        check_field("incorrect_total", 64'(exp_res.incorrect_total),
                    64'(got_res.incorrect_total));
        check_field("loss_total", 64'(exp_res.loss_total), 64'(got_res.loss_total));
        check_field("padding", 64'd0, 64'(m_tdata[cel_pkg::OUT_TW-1:cel_pkg::OUT_W]));
      end
    end
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    int       phase;
    int       cur_phase;
    int       len;
    int       hot;
    int       style;
    logic     long_done;
    logic [cel_pkg::PROB_W-1:0] p;
    logic [cel_pkg::PROB_W-1:0] t;

    arg_best_prob = '0;
    arg_best_idx = '0;
    elem_idx = '0;
    hot_idx = '0;
    sample_loss_acc = '0;
    hit_cnt = '0;
    miss_cnt = '0;
    loss_acc_total = '0;
    long_done = 1'b0;
    cur_phase = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples: certain prob, zero prob, one LSB, half with prob above one
    add_row(16'd32768, 16'd32768, 1'b1, 1'b1, 24'd0, 10'd0, 10'd0, 1'b1);
    add_row(16'd0, 16'd0, 1'b1, 1'b1, 24'd0, 10'd0, 10'd0, 1'b1);
    add_row(16'd1, 16'd1, 1'b1, 1'b1, 24'd21, 10'd0, 10'd0, 1'b1);
    add_row(16'd16384, 16'd32768, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(16'hFFFF, 16'd0, 1'b1, 1'b1, 24'd45426, 10'd1, 10'd0, 1'b0);
    // Tie on the maximum: the first one wins
    add_row(16'd1000, 16'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(16'd1000, 16'd32768, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(16'd500, 16'd0, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    // Oversized targets on zero probs drive the sample loss into saturation
    for (int k = 0; k < 12; k++) add_row(16'd0, 16'hFFFF, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(16'd0, 16'hFFFF, 1'b1, 1'b1, cel_pkg::LOSS_MAX, 10'd0, 10'd12, 1'b0);
    // No nonzero target: target index holds its previous value
    add_row(16'd200, 16'd0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(16'd300, 16'd0, 1'b1, 1'b1, 24'd0, 10'd1, 10'd12, 1'b0);

    foreach (directed_rows[i]) send_element(directed_rows[i]);

    // Random samples across the idling phases; the long sample does not advance them
    while (items_sent < ITEM_GOAL) begin
      phase = ((items_sent - (long_done ? LONG_LEN : 0)) * 4) / RAND_GOAL;
      if (phase != cur_phase) begin
        // Hold the sender until every pending sample has come back
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain_results();
        cur_phase = phase;
        tx_idle_pct  = (phase == 1) ? 50 : ((phase == 3) ? 25 : 0);
        rx_stall_pct = (phase == 2) ? 50 : ((phase == 3) ? 25 : 0);
      end
      if (!long_done && items_sent >= 300) begin
        // Long sample: the element index saturates, late max and hot element
        long_done = 1'b1;
        for (int k = 0; k < LONG_LEN; k++) begin
          if (k == 1026) begin
            p = 16'd32768;
            t = 16'd32768;
          end else begin
            p = cel_pkg::PROB_W'($urandom_range(20000));
            t = (k < 1026 && $urandom_range(15) == 0) ?
                cel_pkg::PROB_W'($urandom_range(300)) : '0;
          end
          send_element(rand_element(p, t, k == LONG_LEN - 1));
        end
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
        hot = $urandom_range(len - 1);
        style = $urandom_range(3);
        for (int k = 0; k < len; k++) begin
          p = rand_prob();
          if (style <= 1) begin
            // One-hot target, often with the matching prob on top
            t = (k == hot) ? 16'd32768 : '0;
            if (k == hot && style == 0) p = 16'd32768;
          end else if (style == 2) begin
            t = rand_target();
          end else begin
            t = '0;
          end
          send_element(rand_element(p, t, k == len - 1));
        end
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cel_pkg.sv
hw/rtl/cel_ctrl.sv
hw/rtl/cel_dp.sv
hw/rtl/cross_entropy_loss_accuracy.sv
hw/rtl/cel_checker.sv
tb/sv/tb.sv
